// ===== src/fvbc_pkg.sv =====
// ----------------------------------------------------------------------------
// fvbc_pkg: shared definitions for the fog volume box classifier
// Widths, register indexes, field codes, sequencer states and the result beat.
// ----------------------------------------------------------------------------
package fvbc_pkg;

    localparam int FOG_ENTRIES_DEF = 64;
    localparam int COORD_BITS_DEF  = 32;

    localparam int FOG_COUNT_W = 7;   // fog_count register width
    localparam int IDX_W       = 6;   // fog_index width
    localparam int CFG_IDX_W   = 2;   // config register index width
    localparam int CFG_DATA_W  = 7;   // widest config register
    localparam int PORT_COORD_W = 32; // coordinate port width

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FOG_COUNT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORLD_LOADED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RENDERER_READY = 2'd2;

    // input item kinds
    localparam logic KIND_CORNER = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    // corner selects
    localparam logic CORNER_MIN = 1'b0;
    localparam logic CORNER_MAX = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DONE
    } srch_state_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] index;
    } fvbc_result_t;

endpackage

// ===== src/fog_volume_box_classifier.sv =====
// ----------------------------------------------------------------------------
// fog_volume_box_classifier: fog volume lookup for polygon bounding boxes
//
// Holds a table of fog boxes (min and max corner per slot, one corner written
// per input beat with kind = 0) and grows a bounding box over the vertices of
// the current polygon (kind = 1). On the beat marked last_vertex, with
// renderer_ready set, the block returns the lowest fog index from 1 upward
// whose box overlaps the polygon box, inclusive on every axis, or 0 when none
// does, when world_loaded is clear or when fog_count is 1 or 0. With
// renderer_ready clear the polygon still closes but no result beat is sent.
// Corner writes and vertices are accepted whenever s_ready is high. A closing
// vertex visits fog entries one at a time, each through a read state and then
// a compare state, since the table has one read port and the overlap test is a
// single compare unit.
// s_ready is low during the search. The result sits in an output register,
// so corner writes and vertices are taken while it waits for m_ready.
// Coordinates are signed fixed point with 8 fraction bits; only the low
// min(COORD_BITS, 32) bits of each coordinate are used, sign-extended.
// Fog table contents are undefined until written; there is no clearing pass.
// Config writes are expected only while the block is idle.
// ----------------------------------------------------------------------------
module fog_volume_box_classifier #(
    parameter int FOG_ENTRIES = fvbc_pkg::FOG_ENTRIES_DEF,
    parameter int COORD_BITS  = fvbc_pkg::COORD_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    // config write port
    input  logic                                 cfg_wr_en,
    input  logic [fvbc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fvbc_pkg::CFG_DATA_W-1:0]      cfg_data,

    // input beats
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_kind,
    input  logic [5:0]                           s_fog_slot,
    input  logic                                 s_corner,
    input  logic signed [fvbc_pkg::PORT_COORD_W-1:0] s_coord_x,
    input  logic signed [fvbc_pkg::PORT_COORD_W-1:0] s_coord_y,
    input  logic signed [fvbc_pkg::PORT_COORD_W-1:0] s_coord_z,
    input  logic                                 s_last_vertex,

    // result beats
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [fvbc_pkg::IDX_W-1:0]           m_fog_index
);

    // effective coordinate width
    localparam int CW    = (COORD_BITS < fvbc_pkg::PORT_COORD_W) ? COORD_BITS
                                                                 : fvbc_pkg::PORT_COORD_W;
    localparam int IW    = $clog2(FOG_ENTRIES);
    localparam int SLOT_CMP_W = (IW + 1 > 7) ? IW + 1 : 7;

    // config registers
    logic [fvbc_pkg::FOG_COUNT_W-1:0] fog_count_reg;
    logic                             world_loaded_reg;
    logic                             renderer_ready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fog_count_reg      <= fvbc_pkg::FOG_COUNT_W'(1);
            world_loaded_reg   <= 1'b0;
            renderer_ready_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                fvbc_pkg::CFG_FOG_COUNT:      fog_count_reg      <= cfg_data;
                fvbc_pkg::CFG_WORLD_LOADED:   world_loaded_reg   <= cfg_data[0];
                fvbc_pkg::CFG_RENDERER_READY: renderer_ready_reg <= cfg_data[0];
                default: begin
                    // unused index: write dropped
                end
            endcase
        end
    end

    // input beat decode
    logic                 in_acc;
    logic                 vtx_en;
    logic                 corner_wr;
    logic                 slot_ok;
    logic                 search_start;
    logic                 search_busy;
    logic [3*CW-1:0]      coord_vec;

    assign in_acc    = s_valid && s_ready;
    assign vtx_en    = in_acc && (s_kind == fvbc_pkg::KIND_VERTEX);
    // slots past the table depth are dropped
    assign slot_ok   = SLOT_CMP_W'(s_fog_slot) < SLOT_CMP_W'(FOG_ENTRIES);
    assign corner_wr = in_acc && (s_kind == fvbc_pkg::KIND_CORNER) && slot_ok;
    // polygon closes even with the renderer off; only the search is skipped
    assign search_start = vtx_en && s_last_vertex && renderer_ready_reg;
    assign coord_vec = {CW'(s_coord_z), CW'(s_coord_y), CW'(s_coord_x)};

    assign s_ready = !search_busy;

    // polygon box
    logic [3*CW-1:0] poly_min;
    logic [3*CW-1:0] poly_max;

    fvbc_poly_acc #(
        .COORD_W (CW)
    ) u_poly_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .vtx_en    (vtx_en),
        .vtx_last  (s_last_vertex),
        .vtx_coord (coord_vec),
        .poly_min  (poly_min),
        .poly_max  (poly_max)
    );

    // fog box table
    logic [IW-1:0]   rd_addr;
    logic [3*CW-1:0] box_min;
    logic [3*CW-1:0] box_max;

    fvbc_box_mem #(
        .FOG_ENTRIES (FOG_ENTRIES),
        .COORD_W     (CW)
    ) u_box_mem (
        .aclk      (aclk),
        .wr_en     (corner_wr),
        .wr_corner (s_corner),
        .wr_addr   (IW'(s_fog_slot)),
        .wr_data   (coord_vec),
        .rd_addr   (rd_addr),
        .rd_min    (box_min),
        .rd_max    (box_max)
    );

    // search sequencer
    fvbc_pkg::fvbc_result_t res;
    logic                   out_free;

    fvbc_search #(
        .FOG_ENTRIES (FOG_ENTRIES),
        .COORD_W     (CW)
    ) u_search (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (search_start),
        .world_loaded (world_loaded_reg),
        .fog_count    (fog_count_reg),
        .out_free     (out_free),
        .poly_min     (poly_min),
        .poly_max     (poly_max),
        .box_min      (box_min),
        .box_max      (box_max),
        .rd_addr      (rd_addr),
        .busy         (search_busy),
        .result       (res)
    );

    // output register
    logic                       m_valid_reg, m_valid_next;
    logic [fvbc_pkg::IDX_W-1:0] m_fog_index_reg;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res.valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (res.valid) begin
            m_fog_index_reg <= res.index;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_fog_index = m_fog_index_reg;

    // a closing vertex with the renderer on must start a search
    assert property (@(posedge aclk) disable iff (!aresetn)
        search_start |=> !s_ready)
        else $error("closing vertex did not start a search");

    // a new result beat only appears from a finished search
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(res.valid))
        else $error("result beat without a finished search");

endmodule

// ===== src/fvbc_box_mem.sv =====
// ----------------------------------------------------------------------------
// fvbc_box_mem: fog box table
// One row per fog slot for each corner; three axes per row, registered read.
// ----------------------------------------------------------------------------
module fvbc_box_mem #(
    parameter int FOG_ENTRIES = fvbc_pkg::FOG_ENTRIES_DEF,
    parameter int COORD_W     = fvbc_pkg::COORD_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic                           wr_corner,
    input  logic [$clog2(FOG_ENTRIES)-1:0] wr_addr,
    input  logic [3*COORD_W-1:0]           wr_data,
    input  logic [$clog2(FOG_ENTRIES)-1:0] rd_addr,
    output logic [3*COORD_W-1:0]           rd_min,
    output logic [3*COORD_W-1:0]           rd_max
);

    logic [3*COORD_W-1:0] min_mem [FOG_ENTRIES];
    logic [3*COORD_W-1:0] max_mem [FOG_ENTRIES];
    logic [3*COORD_W-1:0] rd_min_reg;
    logic [3*COORD_W-1:0] rd_max_reg;

    always_ff @(posedge aclk) begin
        if (wr_en && wr_corner == fvbc_pkg::CORNER_MIN) begin
            min_mem[wr_addr] <= wr_data;
        end
        if (wr_en && wr_corner == fvbc_pkg::CORNER_MAX) begin
            max_mem[wr_addr] <= wr_data;
        end
        rd_min_reg <= min_mem[rd_addr];
        rd_max_reg <= max_mem[rd_addr];
    end

    assign rd_min = rd_min_reg;
    assign rd_max = rd_max_reg;

endmodule

// ===== src/fvbc_poly_acc.sv =====
// ----------------------------------------------------------------------------
// fvbc_poly_acc: polygon bounding box accumulator
// Grows min/max per axis over the vertices of one polygon.
// ----------------------------------------------------------------------------
module fvbc_poly_acc #(
    parameter int COORD_W = fvbc_pkg::COORD_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 vtx_en,
    input  logic                 vtx_last,
    input  logic [3*COORD_W-1:0] vtx_coord,
    output logic [3*COORD_W-1:0] poly_min,
    output logic [3*COORD_W-1:0] poly_max
);

    logic signed [COORD_W-1:0] min_reg  [3];
    logic signed [COORD_W-1:0] max_reg  [3];
    logic signed [COORD_W-1:0] min_next [3];
    logic signed [COORD_W-1:0] max_next [3];
    logic                      first_reg;
    logic                      first_next;

    always_comb begin
        logic signed [COORD_W-1:0] cur;
        for (int a = 0; a < 3; a++) begin
            cur = $signed(vtx_coord[a*COORD_W +: COORD_W]);
            min_next[a] = min_reg[a];
            max_next[a] = max_reg[a];
            if (vtx_en) begin
                if (first_reg || cur < min_reg[a]) begin
                    min_next[a] = cur;
                end
                if (first_reg || cur > max_reg[a]) begin
                    max_next[a] = cur;
                end
            end
        end
        first_next = vtx_en ? vtx_last : first_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
            for (int a = 0; a < 3; a++) begin
                min_reg[a] <= '0;
                max_reg[a] <= '0;
            end
        end else begin
            first_reg <= first_next;
            for (int a = 0; a < 3; a++) begin
                min_reg[a] <= min_next[a];
                max_reg[a] <= max_next[a];
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            poly_min[a*COORD_W +: COORD_W] = min_reg[a];
            poly_max[a*COORD_W +: COORD_W] = max_reg[a];
        end
    end

endmodule

// ===== src/fvbc_search.sv =====
// ----------------------------------------------------------------------------
// fvbc_search: first-match overlap search
// Walks fog entries from 1 upward through one box compare unit.
// ----------------------------------------------------------------------------
module fvbc_search #(
    parameter int FOG_ENTRIES = fvbc_pkg::FOG_ENTRIES_DEF,
    parameter int COORD_W     = fvbc_pkg::COORD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic                                world_loaded,
    input  logic [fvbc_pkg::FOG_COUNT_W-1:0]    fog_count,
    input  logic                                out_free,
    input  logic [3*COORD_W-1:0]                poly_min,
    input  logic [3*COORD_W-1:0]                poly_max,
    input  logic [3*COORD_W-1:0]                box_min,
    input  logic [3*COORD_W-1:0]                box_max,
    output logic [$clog2(FOG_ENTRIES)-1:0]      rd_addr,
    output logic                                busy,
    output fvbc_pkg::fvbc_result_t              result
);

    localparam int IW    = $clog2(FOG_ENTRIES);
    localparam int CNT_W = (IW + 1 > fvbc_pkg::FOG_COUNT_W) ? IW + 1 : fvbc_pkg::FOG_COUNT_W;

    fvbc_pkg::srch_state_t          state_reg, state_next;
    logic [IW-1:0]                  i_reg, i_next;
    logic [fvbc_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]               n_lim;
    logic [CNT_W-1:0]               fc_ext;
    logic                           hit;

    // entries in use, saturated to the table depth
    assign fc_ext = CNT_W'(fog_count);
    assign n_lim  = (fc_ext > CNT_W'(FOG_ENTRIES)) ? CNT_W'(FOG_ENTRIES) : fc_ext;

    // inclusive overlap on all three axes
    always_comb begin
        hit = 1'b1;
        for (int a = 0; a < 3; a++) begin
            if ($signed(poly_max[a*COORD_W +: COORD_W]) < $signed(box_min[a*COORD_W +: COORD_W])
                || $signed(poly_min[a*COORD_W +: COORD_W])
                   > $signed(box_max[a*COORD_W +: COORD_W])) begin
                hit = 1'b0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            fvbc_pkg::ST_IDLE: begin
                if (start) begin
                    if (!world_loaded || n_lim <= CNT_W'(1)) begin
                        idx_next   = '0;
                        state_next = fvbc_pkg::ST_DONE;
                    end else begin
                        i_next     = IW'(1);
                        state_next = fvbc_pkg::ST_READ;
                    end
                end
            end
            fvbc_pkg::ST_READ: begin
                state_next = fvbc_pkg::ST_CMP;
            end
            fvbc_pkg::ST_CMP: begin
                if (hit) begin
                    idx_next   = fvbc_pkg::IDX_W'(i_reg);
                    state_next = fvbc_pkg::ST_DONE;
                end else if (CNT_W'(i_reg) + CNT_W'(1) < n_lim) begin
                    i_next     = i_reg + IW'(1);
                    state_next = fvbc_pkg::ST_READ;
                end else begin
                    idx_next   = '0;
                    state_next = fvbc_pkg::ST_DONE;
                end
            end
            fvbc_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = fvbc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fvbc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fvbc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        i_reg   <= i_next;
        idx_reg <= idx_next;
    end

    assign rd_addr      = i_reg;
    assign busy         = (state_reg != fvbc_pkg::ST_IDLE);
    assign result.valid = (state_reg == fvbc_pkg::ST_DONE) && out_free;
    assign result.index = idx_reg;

endmodule

// ===== sim/fog_volume_box_classifier_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fog_volume_box_classifier_tb: self-checking bench for the fog box classifier
// Preloads the fog table, walks a short table of directed beats and register
// writes, then runs six random phases under changing register settings and
// idle patterns. Every accepted input beat goes through a local copy of the
// classifier, and each fog_index beat is checked against the oldest due value.
// ----------------------------------------------------------------------------
module fog_volume_box_classifier_tb;

    localparam int FOG_ENTRIES  = fvbc_pkg::FOG_ENTRIES_DEF;
    localparam int PORT_COORD_W = fvbc_pkg::PORT_COORD_W;
    localparam int CFG_IDX_W    = fvbc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = fvbc_pkg::CFG_DATA_W;
    localparam int IDX_W        = fvbc_pkg::IDX_W;
    localparam int FOG_COUNT_W  = fvbc_pkg::FOG_COUNT_W;
    // worst search visits every table entry with a read and a compare step, plus a little slack
    localparam int SEARCH_DRAIN = 2 * FOG_ENTRIES + 8;
    localparam int RECV_HOLD    = 300;
    localparam int TIMEOUT_NS   = 5_000_000;

    // what a directed row expects: a typed index, nothing, or the predictor
    localparam int WANT_PREDICT = -2;
    localparam int WANT_NONE    = -1;

    localparam int C_MIN = 32'h8000_0000;
    localparam int C_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic                           kind;
        logic [5:0]                     slot;
        logic                           corner;
        logic [2:0][PORT_COORD_W-1:0]   crd;    // [0] x, [1] y, [2] z
        logic                           last;
    } fog_beat_t;

    typedef struct packed {
        logic                   is_cfg;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        fog_beat_t              beat;
        int                     want;
    } stim_row_t;

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_data  = '0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    logic                          s_kind    = 1'b0;
    logic [5:0]                    s_fog_slot = '0;
    logic                          s_corner  = 1'b0;
    logic signed [PORT_COORD_W-1:0] s_coord_x = '0;
    logic signed [PORT_COORD_W-1:0] s_coord_y = '0;
    logic signed [PORT_COORD_W-1:0] s_coord_z = '0;
    logic                          s_last_vertex = 1'b0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    logic [IDX_W-1:0]              m_fog_index;

    fog_volume_box_classifier DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_fog_slot    (s_fog_slot),
        .s_corner      (s_corner),
        .s_coord_x     (s_coord_x),
        .s_coord_y     (s_coord_y),
        .s_coord_z     (s_coord_z),
        .s_last_vertex (s_last_vertex),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_fog_index   (m_fog_index)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor state: fog table, running polygon box, register copies.
    // The table is fully preloaded before any search can touch it.
    // ------------------------------------------------------------------
    logic signed [PORT_COORD_W-1:0] fog_lo [FOG_ENTRIES][3];
    logic signed [PORT_COORD_W-1:0] fog_hi [FOG_ENTRIES][3];
    logic signed [PORT_COORD_W-1:0] poly_lo [3] = '{0, 0, 0};
    logic signed [PORT_COORD_W-1:0] poly_hi [3] = '{0, 0, 0};
    bit                             first_vtx   = 1'b1;
    logic [FOG_COUNT_W-1:0]         fog_count_r = 1;
    bit                             world_r     = 1'b0;
    bit                             ready_r     = 1'b0;

    logic [IDX_W-1:0] fog_idx_due [$];   // fog indexes still owed by the DUT
    int               mismatch_cnt = 0;

    int   send_idle_pct = 11;
    int   recv_idle_pct = 46;
    logic hold_req      = 1'b0;          // one-shot request for a long m_ready hold-off
    logic hold_taken    = 1'b0;
    int   hold_left     = 0;

    stim_row_t dir_rows [$];

    // lowest fog entry from 1 up whose box touches the polygon box
    function automatic logic [IDX_W-1:0] first_fog_hit();
        int n;
        n = (fog_count_r > FOG_ENTRIES) ? FOG_ENTRIES : int'(fog_count_r);
        if (!world_r || n <= 1)
            return '0;
        for (int i = 1; i < n; i++) begin
            if (poly_hi[0] >= fog_lo[i][0] && poly_hi[1] >= fog_lo[i][1] &&
                poly_hi[2] >= fog_lo[i][2] && poly_lo[0] <= fog_hi[i][0] &&
                poly_lo[1] <= fog_hi[i][1] && poly_lo[2] <= fog_hi[i][2])
                return IDX_W'(i);
        end
        return '0;
    endfunction

    task automatic classify_beat(input fog_beat_t b, output bit emits,
                                 output logic [IDX_W-1:0] idx);
        logic signed [PORT_COORD_W-1:0] c;
        emits = 1'b0;
        idx   = '0;
        if (b.kind == fvbc_pkg::KIND_CORNER) begin
            // table update only; polygon in progress is left alone
            for (int a = 0; a < 3; a++) begin
                if (b.corner == fvbc_pkg::CORNER_MIN)
                    fog_lo[b.slot][a] = b.crd[a];
                else
                    fog_hi[b.slot][a] = b.crd[a];
            end
            return;
        end
        for (int a = 0; a < 3; a++) begin
            c = b.crd[a];
            if (first_vtx || c < poly_lo[a])
                poly_lo[a] = c;
            if (first_vtx || c > poly_hi[a])
                poly_hi[a] = c;
        end
        first_vtx = b.last;
        // polygon closes even with the renderer down, but nothing goes out
        if (b.last && ready_r) begin
            emits = 1'b1;
            idx   = first_fog_hit();
        end
    endtask

    // ------------------------------------------------------------------
    // Beat builders
    // ------------------------------------------------------------------
    function automatic fog_beat_t mk_beat(input logic kind, input logic [5:0] slot,
                                          input logic corner, input int x, input int y,
                                          input int z, input logic last);
        fog_beat_t b;
        b.kind   = kind;
        b.slot   = slot;
        b.corner = corner;
        b.crd[0] = x;
        b.crd[1] = y;
        b.crd[2] = z;
        b.last   = last;
        return b;
    endfunction

    function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
        stim_row_t r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = CFG_DATA_W'(val);
        return r;
    endfunction

    function automatic stim_row_t vtx_row(input int x, input int y, input int z,
                                          input logic last, input int want);
        stim_row_t r;
        r      = '0;
        r.beat = mk_beat(fvbc_pkg::KIND_VERTEX, 6'd0, fvbc_pkg::CORNER_MIN, x, y, z, last);
        r.want = want;
        return r;
    endfunction

    function automatic stim_row_t crn_row(input int slot, input logic corner, input int x,
                                          input int y, input int z, input logic last,
                                          input int want);
        stim_row_t r;
        r      = '0;
        r.beat = mk_beat(fvbc_pkg::KIND_CORNER, 6'(slot), corner, x, y, z, last);
        r.want = want;
        return r;
    endfunction

    // small signed value around the origin, where boxes and polygons meet often
    function automatic int near_coord();
        return int'($urandom_range(8192)) - 4096;
    endfunction

    // ------------------------------------------------------------------
    // Input side. Entered just after a falling edge and left the same way.
    // ------------------------------------------------------------------
    task automatic send_beat(input fog_beat_t b, input int want);
        bit               emits;
        logic [IDX_W-1:0] idx;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= b.kind;
        s_fog_slot    <= b.slot;
        s_corner      <= b.corner;
        s_coord_x     <= b.crd[0];
        s_coord_y     <= b.crd[1];
        s_coord_z     <= b.crd[2];
        s_last_vertex <= b.last;
        do @(posedge aclk); while (!s_ready);
        classify_beat(b, emits, idx);
        if (want == WANT_PREDICT) begin
            if (emits)
                fog_idx_due.push_back(idx);
        end else if (want != WANT_NONE) begin
            fog_idx_due.push_back(IDX_W'(want));
        end
        @(negedge aclk);
    endtask

    // drop valid, wait for every owed index, then let a search finish
    task automatic settle_outputs(input int extra);
        s_valid <= 1'b0;
        while (fog_idx_due.size() != 0)
            @(negedge aclk);
        repeat (extra) @(negedge aclk);
    endtask

    // one cycle of write enable, then enable low again before the task returns
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            fvbc_pkg::CFG_FOG_COUNT:      fog_count_r = val;
            fvbc_pkg::CFG_WORLD_LOADED:   world_r     = val[0];
            fvbc_pkg::CFG_RENDERER_READY: ready_r     = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic write_box(input int slot, input bit skip_min, input bit skip_max);
        int lo [3];
        int hi [3];
        for (int a = 0; a < 3; a++) begin
            lo[a] = near_coord();
            // about one axis in ten gets a max at or below its min
            if ($urandom_range(9) == 0)
                hi[a] = lo[a] - int'($urandom_range(512));
            else
                hi[a] = lo[a] + int'($urandom_range(6000));
        end
        if (!skip_min)
            send_beat(mk_beat(fvbc_pkg::KIND_CORNER, 6'(slot), fvbc_pkg::CORNER_MIN,
                              lo[0], lo[1], lo[2], 1'($urandom_range(1))), WANT_PREDICT);
        if (!skip_max)
            send_beat(mk_beat(fvbc_pkg::KIND_CORNER, 6'(slot), fvbc_pkg::CORNER_MAX,
                              hi[0], hi[1], hi[2], 1'($urandom_range(1))), WANT_PREDICT);
    endtask

    // Random traffic: mostly whole polygons of 1..6 vertices clustered around
    // a center, mixed with box rewrites (sometimes only one corner) and lone
    // vertices anywhere in the 32-bit space that may leave a polygon open.
    task automatic run_phase(input int n_items, input int hold_at, input int pause_at);
        int  sent;
        int  pick;
        int  nv;
        int  ctr [3];
        bit  hold_fired;
        bit  pause_fired;
        bit  skip_min;
        bit  skip_max;
        sent        = 0;
        hold_fired  = 1'b0;
        pause_fired = 1'b0;
        while (sent < n_items) begin
            if (!hold_fired && hold_at >= 0 && sent >= hold_at) begin
                hold_req  <= 1'b1;
                hold_fired = 1'b1;
            end
            if (!pause_fired && pause_at >= 0 && sent >= pause_at) begin
                settle_outputs(1);
                pause_fired = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 12) begin
                skip_min = ($urandom_range(7) == 0);
                skip_max = !skip_min && ($urandom_range(7) == 0);
                write_box($urandom_range(FOG_ENTRIES - 1), skip_min, skip_max);
                sent += 2 - int'(skip_min) - int'(skip_max);
            end else if (pick < 20) begin
                send_beat(mk_beat(fvbc_pkg::KIND_VERTEX, 6'($urandom_range(63)),
                                  1'($urandom_range(1)), $urandom(), $urandom(),
                                  $urandom(), 1'($urandom_range(1))),
                          WANT_PREDICT);
                sent++;
            end else begin
                nv = $urandom_range(1, 6);
                for (int a = 0; a < 3; a++)
                    ctr[a] = near_coord();
                for (int v = 0; v < nv; v++) begin
                    send_beat(mk_beat(fvbc_pkg::KIND_VERTEX, 6'($urandom_range(63)),
                                      1'($urandom_range(1)),
                                      ctr[0] + int'($urandom_range(2000)) - 1000,
                                      ctr[1] + int'($urandom_range(2000)) - 1000,
                                      ctr[2] + int'($urandom_range(2000)) - 1000,
                                      v == nv - 1), WANT_PREDICT);
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random m_ready, plus a long hold-off on request so the
    // result register stays full and the next closing vertex backs up.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= RECV_HOLD;
            m_ready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result beats are checked in order against the owed indexes
    always @(posedge aclk) begin : result_check
        logic [IDX_W-1:0] due;
        if (aresetn && m_valid && m_ready) begin
            if (fog_idx_due.size() == 0) begin
                $display("%0t: fog_index beat with none due: expected none, actual %0d",
                         $time, m_fog_index);
                mismatch_cnt++;
            end else begin
                due = fog_idx_due.pop_front();
                if (m_fog_index !== due) begin
                    $display("%0t: fog_index mismatch: expected %0d, actual %0d",
                             $time, due, m_fog_index);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // Directed rows. Slot 1 first spans the whole space, then becomes an
        // inverted box; slot 2 is a 1.0 unit cube at the origin for the
        // inclusive-edge checks.
        dir_rows = '{
            vtx_row(0, 0, 0, 1'b1, WANT_NONE),                 // renderer down after reset
            cfg_row(fvbc_pkg::CFG_RENDERER_READY, 1),
            vtx_row(0, 0, 0, 1'b1, 0),                         // no world loaded
            cfg_row(fvbc_pkg::CFG_WORLD_LOADED, 1),
            vtx_row(C_MAX, C_MAX, C_MAX, 1'b1, 0),             // fog_count 1: no fog
            cfg_row(fvbc_pkg::CFG_FOG_COUNT, 0),
            vtx_row(C_MIN, C_MIN, C_MIN, 1'b1, 0),             // fog_count 0 acts as 1
            crn_row(1, fvbc_pkg::CORNER_MIN, C_MIN, C_MIN, C_MIN, 1'b0, WANT_NONE),
            crn_row(1, fvbc_pkg::CORNER_MAX, C_MAX, C_MAX, C_MAX, 1'b0, WANT_NONE),
            cfg_row(fvbc_pkg::CFG_FOG_COUNT, 64),
            vtx_row(C_MIN, C_MAX, -1, 1'b0, WANT_NONE),
            vtx_row(C_MAX, C_MIN, 0, 1'b1, 1),
            cfg_row(fvbc_pkg::CFG_FOG_COUNT, 127),             // saturates to table size
            vtx_row(C_MAX, C_MAX, C_MAX, 1'b1, 1),
            vtx_row(C_MIN, C_MIN, C_MIN, 1'b1, 1),
            crn_row(1, fvbc_pkg::CORNER_MIN, C_MAX, C_MAX, C_MAX, 1'b0, WANT_NONE),
            crn_row(1, fvbc_pkg::CORNER_MAX, C_MIN, C_MIN, C_MIN, 1'b0, WANT_NONE),
            vtx_row(0, 0, 0, 1'b1, WANT_PREDICT),
            crn_row(63, fvbc_pkg::CORNER_MAX, -1, -1, -1, 1'b1, WANT_NONE), // last ignored
            crn_row(2, fvbc_pkg::CORNER_MIN, 0, 0, 0, 1'b0, WANT_NONE),
            crn_row(2, fvbc_pkg::CORNER_MAX, 256, 256, 256, 1'b0, WANT_NONE),
            cfg_row(fvbc_pkg::CFG_FOG_COUNT, 3),
            vtx_row(256, 256, 256, 1'b1, 2),                   // touches slot 2 max corner
            vtx_row(257, 256, 256, 1'b1, 0),                   // just past it
            cfg_row(fvbc_pkg::CFG_RENDERER_READY, 0),
            vtx_row(5, 5, 5, 1'b0, WANT_NONE),
            vtx_row(-5, -5, -5, 1'b1, WANT_NONE),              // closes silently
            cfg_row(fvbc_pkg::CFG_RENDERER_READY, 1),
            vtx_row(-5, -5, -5, 1'b0, WANT_NONE),
            vtx_row(300, 0, 100, 1'b1, 2)
        };

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // table preload: no search may ever read an unwritten entry
        for (int slot = 0; slot < FOG_ENTRIES; slot++)
            write_box(slot, 1'b0, 1'b0);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].is_cfg) begin
                settle_outputs(SEARCH_DRAIN);
                write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
            end else begin
                send_beat(dir_rows[r].beat, dir_rows[r].want);
            end
        end

        // Six random phases: sender/receiver idle 11/46, then 46/11, then none.
        // Phase 2 runs with the renderer down, phase 3 with no world and a
        // mid-phase drain, phase 5 with the long receiver hold-off.
        for (int p = 0; p < 6; p++) begin
            settle_outputs(SEARCH_DRAIN);
            send_idle_pct  = (p < 2) ? 11 : (p < 4) ? 46 : 0;
            recv_idle_pct <= (p < 2) ? 46 : (p < 4) ? 11 : 0;
            case (p)
                0:       write_reg(fvbc_pkg::CFG_FOG_COUNT, CFG_DATA_W'(64));
                1:       write_reg(fvbc_pkg::CFG_FOG_COUNT, CFG_DATA_W'(2));
                2:       write_reg(fvbc_pkg::CFG_FOG_COUNT, CFG_DATA_W'(127));
                3:       write_reg(fvbc_pkg::CFG_FOG_COUNT,
                                   CFG_DATA_W'($urandom_range(3, 63)));
                4:       write_reg(fvbc_pkg::CFG_FOG_COUNT,
                                   CFG_DATA_W'($urandom_range(0, 127)));
                default: write_reg(fvbc_pkg::CFG_FOG_COUNT, CFG_DATA_W'(64));
            endcase
            write_reg(fvbc_pkg::CFG_WORLD_LOADED, CFG_DATA_W'((p == 3) ? 0 : 1));
            write_reg(fvbc_pkg::CFG_RENDERER_READY, CFG_DATA_W'((p == 2) ? 0 : 1));
            run_phase(60, (p == 5) ? 30 : -1, (p == 3) ? 40 : -1);
        end

        settle_outputs(SEARCH_DRAIN);
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== fog_volume_box_classifier.f =====
src/fvbc_pkg.sv
src/fvbc_box_mem.sv
src/fvbc_poly_acc.sv
src/fvbc_search.sv
src/fog_volume_box_classifier.sv
sim/fog_volume_box_classifier_tb.sv
